// ===== hdl/rlp_pkg.sv =====
package rlp_pkg;

   localparam int LINE_BUFFER_BYTES = 128;
   localparam int COUNT_W = $clog2(LINE_BUFFER_BYTES);
   localparam int PREFIX_COUNT = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_LF = 8'h0a;
   localparam logic [7:0] CHAR_VT = 8'h0b;
   localparam logic [7:0] CHAR_FF = 8'h0c;
   localparam logic [7:0] CHAR_CR = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS = 8'h2b;
   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   typedef enum logic [3:0] {
      CLS_CR,
      CLS_LF,
      CLS_NUL,
      CLS_COMMA,
      CLS_BLANK,
      CLS_PLUS,
      CLS_MINUS,
      CLS_DIGIT,
      CLS_OTHER
   } byte_class_type;

   typedef struct packed {
      byte_class_type cls;
      logic [7:0]     rx_byte;
   } queue_entry_type;

   typedef enum logic [1:0] {
      PH_BEFORE,
      PH_SIGN,
      PH_DIGITS,
      PH_DONE
   } number_phase_type;

   typedef enum logic [2:0] {
      KIND_UNKNOWN,
      KIND_PONG,
      KIND_ACK,
      KIND_BUSY,
      KIND_DONE,
      KIND_ERROR
   } reply_kind_type;

   function automatic logic [3:0] prefix_len(input logic [2:0] k);
      logic [3:0] len;
      case (k)
         3'd0: len = 4'd9;
         3'd1: len = 4'd8;
         3'd2: len = 4'd9;
         3'd3: len = 4'd9;
         3'd4: len = 4'd10;
         default: len = 4'd0;
      endcase
      return len;
   endfunction

   // The first character of each prefix sits in the top byte.
   function automatic logic [7:0] prefix_char(input logic [2:0] k, input logic [3:0] pos);
      logic [79:0] text;
      logic [79:0] shifted;
      case (k)
         3'd0: text = {"ARM,PONG,", 8'h00};
         3'd1: text = {"ARM,ACK,", 16'h0000};
         3'd2: text = {"ARM,BUSY,", 8'h00};
         3'd3: text = {"ARM,DONE,", 8'h00};
         3'd4: text = "ARM,ERROR,";
         default: text = '0;
      endcase
      shifted = text << {pos, 3'b000};
      return shifted[79:72];
   endfunction

endpackage

// ===== hdl/rlp_front.sv =====
module rlp_front (
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,  // rx_byte [7:0]
   output logic                    q_push_valid,
   output rlp_pkg::queue_entry_type q_push_entry,
   input  logic                    q_push_ready
);

   rlp_pkg::byte_class_type cls;

   always_comb begin
      case (req_tdata) inside
         rlp_pkg::CHAR_CR: cls = rlp_pkg::CLS_CR;
         rlp_pkg::CHAR_LF: cls = rlp_pkg::CLS_LF;
         rlp_pkg::CHAR_NUL: cls = rlp_pkg::CLS_NUL;
         rlp_pkg::CHAR_COMMA: cls = rlp_pkg::CLS_COMMA;
         rlp_pkg::CHAR_SPACE, rlp_pkg::CHAR_TAB, rlp_pkg::CHAR_VT, rlp_pkg::CHAR_FF:
            cls = rlp_pkg::CLS_BLANK;
         rlp_pkg::CHAR_PLUS: cls = rlp_pkg::CLS_PLUS;
         rlp_pkg::CHAR_MINUS: cls = rlp_pkg::CLS_MINUS;
         [rlp_pkg::CHAR_ZERO:rlp_pkg::CHAR_NINE]: cls = rlp_pkg::CLS_DIGIT;
         default: cls = rlp_pkg::CLS_OTHER;
      endcase
   end

   // Carriage returns are consumed here and never reach the queue.
   assign req_tready = q_push_ready;
   assign q_push_valid = req_tvalid && (cls != rlp_pkg::CLS_CR);
   assign q_push_entry.cls = cls;
   assign q_push_entry.rx_byte = req_tdata;

endmodule

// ===== hdl/rlp_queue.sv =====
module rlp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  rlp_pkg::queue_entry_type push_entry,
   output logic                     push_ready,
   output logic                     pop_valid,
   output rlp_pkg::queue_entry_type pop_entry,
   input  logic                     pop_ready
);

   rlp_pkg::queue_entry_type entries_ff [rlp_pkg::QUEUE_DEPTH];
   rlp_pkg::queue_entry_type entries_in [rlp_pkg::QUEUE_DEPTH];
   logic [rlp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rlp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rlp_pkg::QPTR_W:0]   count_ff, count_in;
   logic                       push, pop;

   assign push_ready = (count_ff != (rlp_pkg::QPTR_W + 1)'(rlp_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         entries_in[wr_ptr_ff] = push_entry;
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/rlp_back.sv =====
module rlp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_pop_valid,
   input  rlp_pkg::queue_entry_type q_pop_entry,
   output logic                     q_pop_ready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [31:0]              rsp_tdata
);

   logic [rlp_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [rlp_pkg::PREFIX_COUNT-1:0] flags_ff, flags_in;
   logic [1:0]                   comma_ff, comma_in;
   rlp_pkg::number_phase_type    phase_ff, phase_in;
   logic                         neg_ff, neg_in;
   logic [15:0]                  value_ff, value_in;
   logic                         ovf_ff, ovf_in;
   logic                         ended_ff, ended_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [31:0]                  rsp_data_ff, rsp_data_in;

   logic                         pop;
   logic                         emit;
   logic [7:0]                   b;
   rlp_pkg::byte_class_type      cls;
   logic [19:0]                  digit_sum;
   rlp_pkg::reply_kind_type      kind;
   logic [15:0]                  seq;
   logic [6:0]                   len;

   assign q_pop_ready = !rsp_valid_ff || rsp_tready;
   assign pop = q_pop_valid && q_pop_ready;
   assign b = q_pop_entry.rx_byte;
   assign cls = q_pop_entry.cls;
   assign digit_sum = ({4'b0000, value_ff} << 3) + ({4'b0000, value_ff} << 1)
                      + {16'h0000, b[3:0]};

   // Line state update.
   always_comb begin
      count_in = count_ff;
      flags_in = flags_ff;
      comma_in = comma_ff;
      phase_in = phase_ff;
      neg_in = neg_ff;
      value_in = value_ff;
      ovf_in = ovf_ff;
      ended_in = ended_ff;
      if (pop) begin
         if (cls == rlp_pkg::CLS_LF || count_ff >= rlp_pkg::COUNT_W'(rlp_pkg::LINE_BUFFER_BYTES - 1)) begin
            if (cls != rlp_pkg::CLS_LF || count_ff != '0) begin
               count_in = '0;
               flags_in = '1;
               comma_in = 2'd0;
               phase_in = rlp_pkg::PH_BEFORE;
               neg_in = 1'b0;
               value_in = '0;
               ovf_in = 1'b0;
               ended_in = 1'b0;
            end
         end else begin
            count_in = count_ff + 1'b1;
            for (int k = 0; k < rlp_pkg::PREFIX_COUNT; k++) begin
               if (count_ff < rlp_pkg::COUNT_W'(rlp_pkg::prefix_len(3'(k))) &&
                   b != rlp_pkg::prefix_char(3'(k), count_ff[3:0])) begin
                  flags_in[k] = 1'b0;
               end
            end
            if (!ended_ff) begin
               if (cls == rlp_pkg::CLS_NUL) begin
                  ended_in = 1'b1;
               end else if (comma_ff != 2'd2) begin
                  if (cls == rlp_pkg::CLS_COMMA) begin
                     comma_in = comma_ff + 1'b1;
                  end
               end else begin
                  case (phase_ff)
                     rlp_pkg::PH_BEFORE: begin
                        case (cls)
                           rlp_pkg::CLS_BLANK: phase_in = rlp_pkg::PH_BEFORE;
                           rlp_pkg::CLS_PLUS: phase_in = rlp_pkg::PH_SIGN;
                           rlp_pkg::CLS_MINUS: begin
                              neg_in = 1'b1;
                              phase_in = rlp_pkg::PH_SIGN;
                           end
                           rlp_pkg::CLS_DIGIT: begin
                              ovf_in = ovf_ff || (digit_sum[19:16] != 4'h0);
                              value_in = digit_sum[15:0];
                              phase_in = rlp_pkg::PH_DIGITS;
                           end
                           default: phase_in = rlp_pkg::PH_DONE;
                        endcase
                     end
                     rlp_pkg::PH_SIGN, rlp_pkg::PH_DIGITS: begin
                        if (cls == rlp_pkg::CLS_DIGIT) begin
                           ovf_in = ovf_ff || (digit_sum[19:16] != 4'h0);
                           value_in = digit_sum[15:0];
                           phase_in = rlp_pkg::PH_DIGITS;
                        end else begin
                           phase_in = rlp_pkg::PH_DONE;
                        end
                     end
                     default: phase_in = phase_ff;
                  endcase
               end
            end
         end
      end
   end

   // Result formation.
   always_comb begin
      kind = rlp_pkg::KIND_UNKNOWN;
      for (int k = rlp_pkg::PREFIX_COUNT - 1; k >= 0; k--) begin
         if (flags_ff[k] && count_ff >= rlp_pkg::COUNT_W'(rlp_pkg::prefix_len(3'(k)))) begin
            kind = rlp_pkg::reply_kind_type'(3'(k + 1));
         end
      end
      if (comma_ff == 2'd2 && !ovf_ff && !(neg_ff && value_ff != '0)) begin
         seq = value_ff;
      end else begin
         seq = '0;
      end
      len = 7'(count_ff);
      emit = pop && (cls == rlp_pkg::CLS_LF) && (count_ff != '0);
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = {6'b000000, len, seq, kind};
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
         rsp_data_in = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         count_ff <= '0;
         flags_ff <= '1;
         comma_ff <= 2'd0;
         phase_ff <= rlp_pkg::PH_BEFORE;
         neg_ff <= 1'b0;
         value_ff <= '0;
         ovf_ff <= 1'b0;
         ended_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         flags_ff <= flags_in;
         comma_ff <= comma_in;
         phase_ff <= phase_in;
         neg_ff <= neg_in;
         value_ff <= value_in;
         ovf_ff <= ovf_in;
         ended_ff <= ended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

`ifndef SYNTHESIS
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[25:19] != 7'd0))
      else $error("A reported line has zero length.");
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[2:0] <= 3'd5))
      else $error("A reported kind is out of range.");
   a_comma_sat: assert property (@(posedge clock) disable iff (reset)
      comma_ff <= 2'd2)
      else $error("The comma count went past two.");
   a_phase_after_commas: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != rlp_pkg::PH_BEFORE) |-> (comma_ff == 2'd2))
      else $error("Number parsing started before the second comma.");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("A stalled result changed.");
`endif

endmodule

// ===== hdl/reply_line_parser_unit.sv =====
// A line feed is registered in the queue and its result in the output register before it appears
// on rsp; earlier queued bytes or a stalled output register hold it back.
// Throughput: one byte per cycle while the queue has room; carriage returns are accepted but never queued.
// The front classifies each byte and a four-entry queue feeds the back, which updates the
// line state for each byte that it pops and holds the result in an output register.
// Reset clears the line state, the queue and the output register; no result is pending.
module reply_line_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // rx_byte [7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // reply_kind [2:0], reply_sequence [18:3], line_length [25:19]
);

   logic                     q_push_valid;
   rlp_pkg::queue_entry_type q_push_entry;
   logic                     q_push_ready;
   logic                     q_pop_valid;
   rlp_pkg::queue_entry_type q_pop_entry;
   logic                     q_pop_ready;

   rlp_front u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .q_push_valid (q_push_valid),
      .q_push_entry (q_push_entry),
      .q_push_ready (q_push_ready)
   );

   rlp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_entry (q_push_entry),
      .push_ready (q_push_ready),
      .pop_valid  (q_pop_valid),
      .pop_entry  (q_pop_entry),
      .pop_ready  (q_pop_ready)
   );

   rlp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_pop_valid (q_pop_valid),
      .q_pop_entry (q_pop_entry),
      .q_pop_ready (q_pop_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== tb/tb_reply_line_parser_unit.sv =====
module tb_reply_line_parser_unit;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_BYTES = 1850;

   typedef struct {
      rlp_pkg::reply_kind_type kind;
      logic [15:0]             seq_num;
      logic [6:0]              line_len;
   } reply_entry_type;

   class reply_scoreboard;
      reply_entry_type pending_replies[$];
      int unsigned mismatches;
      int unsigned replies_checked;
      int unsigned bytes_noted;
      string prefix_text[rlp_pkg::PREFIX_COUNT];

      logic [rlp_pkg::COUNT_W-1:0] stored_count;
      logic [4:0]                  prefix_live;
      logic [1:0]                  comma_count;
      rlp_pkg::number_phase_type   phase;
      bit                          negative;
      logic [15:0]                 value;
      bit                          value_wrapped;
      bit                          text_ended;

      function new();
         prefix_text[0] = "ARM,PONG,";
         prefix_text[1] = "ARM,ACK,";
         prefix_text[2] = "ARM,BUSY,";
         prefix_text[3] = "ARM,DONE,";
         prefix_text[4] = "ARM,ERROR,";
         mismatches = 0;
         replies_checked = 0;
         bytes_noted = 0;
         clear_line();
      endfunction

      function void clear_line();
         stored_count = '0;
         prefix_live = '1;
         comma_count = '0;
         phase = rlp_pkg::PH_BEFORE;
         negative = 1'b0;
         value = '0;
         value_wrapped = 1'b0;
         text_ended = 1'b0;
      endfunction

      function void add_digit(logic [7:0] b);
         int unsigned t;
         t = value * 10 + (b - rlp_pkg::CHAR_ZERO);
         if (t > 65535) value_wrapped = 1'b1;
         value = t[15:0];
         phase = rlp_pkg::PH_DIGITS;
      endfunction

      function void parse_char(logic [7:0] b);
         bit is_digit;
         is_digit = (b >= rlp_pkg::CHAR_ZERO) && (b <= rlp_pkg::CHAR_NINE);
         for (int k = 0; k < rlp_pkg::PREFIX_COUNT; k++) begin
            if (stored_count < prefix_text[k].len() && b != prefix_text[k][stored_count])
               prefix_live[k] = 1'b0;
         end
         if (text_ended) return;
         if (b == rlp_pkg::CHAR_NUL) begin
            text_ended = 1'b1;
            return;
         end
         if (comma_count < 2) begin
            if (b == rlp_pkg::CHAR_COMMA) comma_count++;
            return;
         end
         case (phase)
            rlp_pkg::PH_BEFORE: begin
               if (b == rlp_pkg::CHAR_SPACE || b == rlp_pkg::CHAR_TAB ||
                   b == rlp_pkg::CHAR_VT || b == rlp_pkg::CHAR_FF) begin
               end else if (b == rlp_pkg::CHAR_PLUS) begin
                  phase = rlp_pkg::PH_SIGN;
               end else if (b == rlp_pkg::CHAR_MINUS) begin
                  negative = 1'b1;
                  phase = rlp_pkg::PH_SIGN;
               end else if (is_digit) begin
                  add_digit(b);
               end else begin
                  phase = rlp_pkg::PH_DONE;
               end
            end
            rlp_pkg::PH_SIGN, rlp_pkg::PH_DIGITS: begin
               if (is_digit) add_digit(b);
               else phase = rlp_pkg::PH_DONE;
            end
            default: begin
            end
         endcase
      endfunction

      function void note_byte(logic [7:0] b);
         reply_entry_type r;
         bit found;
         bytes_noted++;
         if (b == rlp_pkg::CHAR_CR) return;
         if (b == rlp_pkg::CHAR_LF) begin
            if (stored_count == 0) return;
            r.kind = rlp_pkg::KIND_UNKNOWN;
            r.seq_num = '0;
            r.line_len = stored_count[6:0];
            found = 1'b0;
            for (int k = 0; k < rlp_pkg::PREFIX_COUNT; k++) begin
               if (!found && prefix_live[k] && stored_count >= prefix_text[k].len()) begin
                  r.kind = rlp_pkg::reply_kind_type'(k + 1);
                  found = 1'b1;
               end
            end
            if (comma_count == 2 && !value_wrapped && !(negative && value != 0))
               r.seq_num = value;
            pending_replies.push_back(r);
            clear_line();
            return;
         end
         if (stored_count < rlp_pkg::LINE_BUFFER_BYTES - 1) begin
            parse_char(b);
            stored_count++;
         end else begin
            clear_line();
         end
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task check_reply(logic [31:0] data);
         reply_entry_type exp_r;
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected reply transaction %h", data));
            return;
         end
         exp_r = pending_replies.pop_front();
         replies_checked++;
         if (data[2:0] !== exp_r.kind)
            report_mismatch($sformatf("reply_kind %0d, expected %0d", data[2:0], exp_r.kind));
         if (data[18:3] !== exp_r.seq_num)
            report_mismatch($sformatf("reply_sequence %0d, expected %0d",
                                      data[18:3], exp_r.seq_num));
         if (data[25:19] !== exp_r.line_len)
            report_mismatch($sformatf("line_length %0d, expected %0d",
                                      data[25:19], exp_r.line_len));
      endtask
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   reply_scoreboard sb = new();
   logic [7:0]      byte_q[$];
   bit              calm_phase = 1'b0;
   int unsigned     cycle_count = 0;
   int unsigned     rsp_stall_left = 0;

   reply_line_parser_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_reply(rsp_tdata);
   end

   always @(negedge clock) begin
      if (calm_phase || (cycle_count / 600) % 3 == 0) begin
         rsp_tready <= 1'b1;
      end else if (rsp_stall_left != 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [7:0] random_text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == rlp_pkg::CHAR_LF);
      return b;
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 3))
         0: return rlp_pkg::CHAR_SPACE;
         1: return rlp_pkg::CHAR_TAB;
         2: return rlp_pkg::CHAR_VT;
         default: return rlp_pkg::CHAR_FF;
      endcase
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
   endfunction

   function automatic void add_random_line();
      logic [7:0]  line_q[$];
      string       text;
      int unsigned mode;
      int unsigned pick;
      int unsigned n;
      mode = $urandom_range(0, 19);
      if (mode == 0) begin
         if ($urandom_range(0, 1) == 1) line_q.push_back(rlp_pkg::CHAR_CR);
      end else if (mode == 1) begin
         case ($urandom_range(0, 4))
            0: n = 126;
            1: n = 127;
            2: n = 128;
            3: n = 129;
            default: n = $urandom_range(130, 200);
         endcase
         repeat (n) line_q.push_back(8'($urandom_range(33, 126)));
      end else if (mode == 2) begin
         repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         pick = $urandom_range(0, rlp_pkg::PREFIX_COUNT + 1);
         text = sb.prefix_text[pick % rlp_pkg::PREFIX_COUNT];
         if (pick == rlp_pkg::PREFIX_COUNT)
            text[$urandom_range(0, text.len() - 1)] = random_text_byte();
         else if (pick == rlp_pkg::PREFIX_COUNT + 1)
            text = text.substr(0, $urandom_range(0, text.len() - 2));
         for (int i = 0; i < text.len(); i++) line_q.push_back(text[i]);
         repeat ($urandom_range(0, 2)) line_q.push_back(blank_byte());
         case ($urandom_range(0, 5))
            1: line_q.push_back(rlp_pkg::CHAR_PLUS);
            2: line_q.push_back(rlp_pkg::CHAR_MINUS);
            3: begin
               line_q.push_back(rlp_pkg::CHAR_PLUS);
               line_q.push_back(rlp_pkg::CHAR_MINUS);
            end
            default: begin
            end
         endcase
         case ($urandom_range(0, 5))
            0: text = "";
            1: text = "65535";
            2: text = $sformatf("%0d", $urandom_range(65536, 9999999));
            3: text = $sformatf("000%0d", $urandom_range(0, 999));
            4: text = "0";
            default: text = $sformatf("%0d", $urandom_range(0, 65535));
         endcase
         for (int i = 0; i < text.len(); i++) line_q.push_back(text[i]);
         case ($urandom_range(0, 3))
            0: begin
               line_q.push_back(rlp_pkg::CHAR_COMMA);
               line_q.push_back(8'($urandom_range(33, 126)));
            end
            1: repeat ($urandom_range(1, 6)) line_q.push_back(random_text_byte());
            default: begin
            end
         endcase
         if ($urandom_range(0, 9) == 0)
            line_q.insert($urandom_range(0, line_q.size()), rlp_pkg::CHAR_NUL);
         if ($urandom_range(0, 5) == 0)
            line_q.insert($urandom_range(0, line_q.size()), rlp_pkg::CHAR_CR);
      end
      foreach (line_q[i]) byte_q.push_back(line_q[i]);
      byte_q.push_back(rlp_pkg::CHAR_LF);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      if (!calm_phase && (cycle_count / 600) % 3 != 0 && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(b);
      @(negedge clock);
   endtask

   initial begin
      int unsigned calm_from;
      int unsigned directed_count;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty lines, a line with a high byte and a NUL, then an acknowledge at the top value.
      byte_q.push_back(rlp_pkg::CHAR_LF);
      byte_q.push_back(rlp_pkg::CHAR_CR);
      byte_q.push_back(rlp_pkg::CHAR_LF);
      byte_q.push_back(8'hFF);
      byte_q.push_back(rlp_pkg::CHAR_NUL);
      byte_q.push_back(rlp_pkg::CHAR_LF);
      push_text("ARM,ACK, +65535");
      byte_q.push_back(rlp_pkg::CHAR_CR);
      byte_q.push_back(rlp_pkg::CHAR_LF);
      directed_count = byte_q.size();

      while (byte_q.size() < directed_count + RANDOM_BYTES) add_random_line();
      calm_from = byte_q.size() * 85 / 100;

      foreach (byte_q[i]) begin
         calm_phase = (i >= calm_from);
         send_byte(byte_q[i]);
      end
      req_tvalid <= 1'b0;

      while (sb.pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d bytes as reply lines; %0d replies checked, %0d mismatches.",
               sb.bytes_noted, sb.replies_checked, sb.mismatches);
      $display("Lines spanned every reply kind, signed and padded sequences, NULs and overflow.");
      if (sb.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
